// ===== rtl/core/psg_pkg.sv =====
// Package for the pulse sequence generator: sizes, command codes and the
// transaction and internal struct types. No dependencies.
`default_nettype none

package psg_pkg;

    localparam int SEQ_DEPTH = 64;
    localparam int DUR_W     = 32;
    localparam int IDX_W     = $clog2(SEQ_DEPTH);
    localparam int CFG_LEN_W = 7;
    localparam int POS_W     = CFG_LEN_W;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_LOAD  = 2'd3
    } t_cmd;

    typedef logic [DUR_W-1:0]     t_dur;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [POS_W-1:0]     t_pos;
    typedef logic [CFG_LEN_W-1:0] t_len;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  entry_index;
        logic        entry_level;
        logic [31:0] entry_duration;
        logic        loop_enable;
    } t_in_item;

    typedef struct packed {
        logic pin_level;
        logic running;
        logic entry_started;
        logic start_rejected;
    } t_out_item;

    typedef struct packed {
        logic level;
        t_dur dur;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_idx   idx;
        t_entry data;
    } t_tbl_wr;

    typedef struct packed {
        logic running;
        logic ticks_zero;
    } t_eng_status;

endpackage

`default_nettype wire

// ===== rtl/core/pulse_sequence_generator_unit.sv =====
// Top level of the pulse sequence generator: input register, playback engine,
// entry table and result register. Depends on psg_pkg, psg_table, psg_engine.
`default_nettype none

// Pulse sequence generator. Plays a 64-entry table of (pin level, duration)
// pairs on one pin, counting one microsecond per tick transaction. Commands:
// tick, start (from entry 0, loop flag taken from loop_enable), stop (pin low),
// load entry (writes one slot, stops playback). Every input transaction gives
// exactly one result transaction with the pin level and status after it.
// Throughput is one transaction per clock while the output side does not
// stall. An accepted transaction sits in the input register while the engine
// computes its result, which is captured in the result register as the
// transaction advances; an output stall holds it in the input register. The
// table read registers the entry at the current play position, addressed
// from the next position, so consecutive entry changes on back-to-back ticks
// need no stall; entry 0 is held in a separate register for start and wrap.
// The result register stays full while the output side stalls and the input
// register keeps taking transactions until both are occupied.
// sequence_length (0..127, values above 64 act as 64) is written through
// i_cfg_we/i_cfg_data; write it only while no transaction is in flight.
// A zero-length start is refused and flagged in start_rejected. Table slots
// hold no reset value; entries must be loaded before they are played.

module pulse_sequence_generator_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire psg_pkg::t_in_item   i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output psg_pkg::t_out_item       o_out,
    input  wire logic                i_cfg_we,
    input  wire logic [6:0]          i_cfg_data
);
    import psg_pkg::*;

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;
    t_len        r_seq_len;

    logic        adv;
    t_out_item   result;
    t_idx        rd_addr;
    t_tbl_wr     tbl_wr;
    t_entry      rd_data;
    t_entry      entry0;
    t_eng_status eng_status;

    // a transaction moves from the input register to the result register
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_seq_len   <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_seq_len <= t_len'(i_cfg_data);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
        if (adv) begin
            r_out <= result;
        end
    end

    psg_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (adv),
        .i_item    (r_in),
        .i_seq_len (r_seq_len),
        .i_rd_data (rd_data),
        .i_entry0  (entry0),
        .o_rd_addr (rd_addr),
        .o_wr      (tbl_wr),
        .o_result  (result),
        .o_status  (eng_status)
    );

    psg_table u_table (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .o_entry0  (entry0)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a stopped sequence always leaves the pin low
    a_pin_low_when_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.running) |-> !o_out.pin_level)
        else $error("pin high in a stopped result");

    // an entry only starts on a running sequence, and never with a refusal
    a_started_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.entry_started) |-> (o_out.running && !o_out.start_rejected))
        else $error("entry started without running or with refusal");

    // while playing, the countdown never rests at zero
    a_ticks_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_status.running |-> !eng_status.ticks_zero)
        else $error("countdown at zero while running");

endmodule

`default_nettype wire

// ===== rtl/core/psg_table.sv =====
// Entry table: one write port, one registered read port, plus a register copy
// of entry 0 for wrap and start. Depends on psg_pkg.
`default_nettype none

module psg_table (
    input  wire logic            i_clk,
    input  wire psg_pkg::t_tbl_wr i_wr,
    input  wire psg_pkg::t_idx   i_rd_addr,
    output psg_pkg::t_entry      o_rd_data,
    output psg_pkg::t_entry      o_entry0
);
    import psg_pkg::*;

    t_entry r_mem [SEQ_DEPTH];
    t_entry r_rd;
    t_entry r_ent0;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
        // write-first on an address collision
        if (i_wr.en && (i_wr.idx == i_rd_addr)) begin
            r_rd <= i_wr.data;
        end else begin
            r_rd <= r_mem[i_rd_addr];
        end
        if (i_wr.en && (i_wr.idx == '0)) begin
            r_ent0 <= i_wr.data;
        end
    end

    assign o_rd_data = r_rd;
    assign o_entry0  = r_ent0;

endmodule

`default_nettype wire

// ===== rtl/core/psg_engine.sv =====
// Playback state and per-transaction update: countdown, entry advance, start,
// stop and table load. Depends on psg_pkg.
`default_nettype none

module psg_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire psg_pkg::t_in_item  i_item,
    input  wire psg_pkg::t_len      i_seq_len,
    input  wire psg_pkg::t_entry    i_rd_data,
    input  wire psg_pkg::t_entry    i_entry0,
    output psg_pkg::t_idx           o_rd_addr,
    output psg_pkg::t_tbl_wr        o_wr,
    output psg_pkg::t_out_item      o_result,
    output psg_pkg::t_eng_status    o_status
);
    import psg_pkg::*;

    t_pos   r_pos,   n_pos;
    t_dur   r_ticks, n_ticks;
    logic   r_run,   n_run;
    logic   r_loop,  n_loop;
    logic   r_pin,   n_pin;

    t_len   len_eff;
    logic   wrap;
    t_entry ent_sel;
    t_dur   ent_sel_ticks;
    t_dur   ent0_ticks;
    t_dur   tick_dec;
    t_cmd   cmd;
    logic   started;
    logic   rejected;

    assign cmd     = t_cmd'(i_item.cmd);
    assign len_eff = (i_seq_len > t_len'(SEQ_DEPTH)) ? t_len'(SEQ_DEPTH) : i_seq_len;
    assign wrap    = (r_pos >= t_pos'(len_eff));
    assign ent_sel = wrap ? i_entry0 : i_rd_data;

    // zero duration plays as one tick
    assign ent_sel_ticks = (ent_sel.dur == '0) ? t_dur'(1) : ent_sel.dur;
    assign ent0_ticks    = (i_entry0.dur == '0) ? t_dur'(1) : i_entry0.dur;
    assign tick_dec      = (r_ticks != '0) ? (r_ticks - t_dur'(1)) : r_ticks;

    always_comb begin
        n_pos    = r_pos;
        n_ticks  = r_ticks;
        n_run    = r_run;
        n_loop   = r_loop;
        n_pin    = r_pin;
        started  = 1'b0;
        rejected = 1'b0;
        o_wr     = '0;
        if (i_fire) begin
            unique case (cmd)
                CMD_TICK: begin
                    if (r_run) begin
                        n_ticks = tick_dec;
                        if (tick_dec == '0) begin
                            if (wrap && !r_loop) begin
                                n_run = 1'b0;
                                n_pin = 1'b0;
                            end else begin
                                n_pin   = ent_sel.level;
                                n_ticks = ent_sel_ticks;
                                n_pos   = wrap ? t_pos'(1) : (r_pos + t_pos'(1));
                                started = 1'b1;
                            end
                        end
                    end
                end
                CMD_START: begin
                    if (len_eff == '0) begin
                        rejected = 1'b1;
                    end else begin
                        n_loop  = i_item.loop_enable;
                        n_run   = 1'b1;
                        n_pin   = i_entry0.level;
                        n_ticks = ent0_ticks;
                        n_pos   = t_pos'(1);
                        started = 1'b1;
                    end
                end
                CMD_STOP: begin
                    n_run = 1'b0;
                    n_pin = 1'b0;
                end
                CMD_LOAD: begin
                    n_run           = 1'b0;
                    n_pin           = 1'b0;
                    n_pos           = '0;
                    o_wr.en         = 1'b1;
                    o_wr.idx        = t_idx'(i_item.entry_index);
                    o_wr.data.level = i_item.entry_level;
                    o_wr.data.dur   = i_item.entry_duration[DUR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_ticks <= '0;
            r_run   <= 1'b0;
            r_loop  <= 1'b0;
            r_pin   <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_ticks <= n_ticks;
            r_run   <= n_run;
            r_loop  <= n_loop;
            r_pin   <= n_pin;
        end
    end

    // prefetch the entry at the next position; a position equal to the depth
    // always wraps and uses the entry 0 copy instead
    assign o_rd_addr = n_pos[IDX_W-1:0];

    assign o_result.pin_level      = n_pin;
    assign o_result.running        = n_run;
    assign o_result.entry_started  = started;
    assign o_result.start_rejected = rejected;

    assign o_status.running    = r_run;
    assign o_status.ticks_zero = (r_ticks == '0);

endmodule

`default_nettype wire

// ===== verif/psg_playback_checker.sv =====
// Playback checker for the pulse sequence generator: predicts the result of
// every accepted transaction and compares it with the block's output.
// Depends on psg_pkg.

module psg_playback_checker
    import psg_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_ready,
    input  wire t_in_item  i_in,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_ready,
    input  wire t_out_item i_out,
    input  wire logic      i_cfg_we,
    input  wire t_len      i_cfg_data,
    output int             o_fail_count,
    output int             o_pending
);

    // shadow of the player
    logic      lvl_tbl [SEQ_DEPTH];
    t_dur      dur_tbl [SEQ_DEPTH];
    t_pos      position;
    t_dur      countdown;
    logic      playing;
    logic      looping;
    logic      pin;
    t_len      seq_len;

    t_out_item pin_status_q [$];
    t_out_item want;
    int        fails;

    function automatic int unsigned usable_length();
        return (seq_len > SEQ_DEPTH) ? SEQ_DEPTH : seq_len;
    endfunction

    // move to the entry at position; wrap or halt past the end
    function automatic logic enter_next_entry();
        t_idx slot;
        if (position >= usable_length()) begin
            if (!looping) begin
                playing = 1'b0;
                pin     = 1'b0;
                return 1'b0;
            end
            position = '0;
        end
        slot      = position[IDX_W-1:0];
        pin       = lvl_tbl[slot];
        countdown = (dur_tbl[slot] == '0) ? t_dur'(1) : dur_tbl[slot];
        position  = position + 1'b1;
        return 1'b1;
    endfunction

    function automatic t_out_item next_pin_status(input t_in_item it);
        t_out_item res;
        res = '0;
        case (t_cmd'(it.cmd))
            CMD_TICK: begin
                if (playing) begin
                    if (countdown != '0) countdown = countdown - 1'b1;
                    if (countdown == '0) res.entry_started = enter_next_entry();
                end
            end
            CMD_START: begin
                if (usable_length() == 0) begin
                    res.start_rejected = 1'b1;
                end else begin
                    looping  = it.loop_enable;
                    position = '0;
                    playing  = 1'b1;
                    res.entry_started = enter_next_entry();
                end
            end
            CMD_STOP: begin
                playing = 1'b0;
                pin     = 1'b0;
            end
            default: begin
                playing  = 1'b0;
                pin      = 1'b0;
                position = '0;
                lvl_tbl[it.entry_index] = it.entry_level;
                dur_tbl[it.entry_index] = it.entry_duration;
            end
        endcase
        res.pin_level = pin;
        res.running   = playing;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            position  = '0;
            countdown = '0;
            playing   = 1'b0;
            looping   = 1'b0;
            pin       = 1'b0;
            seq_len   = '0;
            fails     = 0;
            pin_status_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) pin_status_q.push_back(next_pin_status(i_in));
            if (i_out_valid && i_out_ready) begin
                if (pin_status_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("[%0t] unexpected result: pin=%b run=%b start=%b rej=%b",
                                 $time, i_out.pin_level, i_out.running,
                                 i_out.entry_started, i_out.start_rejected);
                end else begin
                    want = pin_status_q.pop_front();
                    if (i_out.pin_level !== want.pin_level ||
                        i_out.running !== want.running ||
                        i_out.entry_started !== want.entry_started ||
                        i_out.start_rejected !== want.start_rejected) begin
                        fails++;
                        if (fails <= 10)
                            $display({"[%0t] result mismatch: expected pin=%b run=%b ",
                                      "start=%b rej=%b, got pin=%b run=%b start=%b rej=%b"},
                                     $time, want.pin_level, want.running,
                                     want.entry_started, want.start_rejected,
                                     i_out.pin_level, i_out.running,
                                     i_out.entry_started, i_out.start_rejected);
                    end
                end
            end
            if (i_cfg_we) seq_len = i_cfg_data;
        end
        o_pending    <= pin_status_q.size();
        o_fail_count <= fails;
    end

endmodule

// ===== verif/pulse_sequence_generator_unit_test.sv =====
// Testbench top for the pulse sequence generator: drives directed and random
// transactions and length settings, gives the verdict.
// Depends on psg_pkg, psg_playback_checker and pulse_sequence_generator_unit.

module pulse_sequence_generator_unit_test;
    import psg_pkg::*;

    // Quiet cycles (nothing accepted on either side) before the run is
    // declared hung. Worst legal quiet stretch is the long output hold-off
    // plus a sender gap, or a drain plus a length write; far below this.
    localparam int IDLE_LIMIT    = 2000;
    localparam int LONG_HOLD     = 160;
    localparam int RANDOM_ITEMS  = 75;   // random transactions per length phase
    localparam int SETTLE_CYCLES = 4;    // settle margin after the last result

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    logic      cfg_we    = 1'b0;
    t_len      cfg_data  = '0;

    int        fail_count;
    int        pending;

    // stimulus bookkeeping
    bit        loaded [SEQ_DEPTH];   // slots written so far; never play an unwritten one
    bit        long_hold_due = 1'b0; // sender asks the sink for one long stall
    int        items_sent    = 0;
    int        send_burst    = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pulse_sequence_generator_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    psg_playback_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic finish_run(input bit passed);
        if (passed)
            $display("PASS pulse_sequence_generator_unit");
        else
            $display("FAIL pulse_sequence_generator_unit");
        $finish;
    endtask

    // Fields that the command ignores stay random so every payload bit toggles.
    function automatic t_in_item shaped_item(input t_cmd cmd);
        t_in_item it;
        it.cmd            = cmd;
        it.entry_index    = 6'($urandom_range(0, SEQ_DEPTH - 1));
        it.entry_level    = 1'($urandom_range(0, 1));
        it.entry_duration = $urandom;
        it.loop_enable    = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Mostly short entries so playback steps through the table; a few long
    // ones, and now and then a full-width value.
    function automatic t_dur shaped_duration();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return t_dur'($urandom_range(0, 6));
        if (r < 94) return t_dur'($urandom_range(0, 60));
        return $urandom;
    endfunction

    // One input transaction: random gap (or none during a burst), then valid
    // held with a stable payload until accepted.
    task automatic offer(input t_in_item it);
        int gap;
        if (send_burst > 0) begin
            send_burst--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 19) == 0) send_burst = $urandom_range(10, 40);
            gap = $urandom_range(0, 18);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!(in_valid && in_ready));
        items_sent++;
        // two long output stalls mid-stream so the pipeline backs up
        if (items_sent == 300 || items_sent == 550) long_hold_due = 1'b1;
    endtask

    task automatic send_cmd(input t_cmd cmd, input logic loop_on);
        t_in_item it;
        it = shaped_item(cmd);
        it.loop_enable = loop_on;
        offer(it);
    endtask

    task automatic send_load(input int unsigned slot, input logic lvl, input t_dur dur);
        t_in_item it;
        it = shaped_item(CMD_LOAD);
        it.entry_index    = t_idx'(slot);
        it.entry_level    = lvl;
        it.entry_duration = dur;
        offer(it);
        loaded[slot] = 1'b1;
    endtask

    // Sender pauses until every result is back, then lets the pipe settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Length register is only touched with the block idle.
    task automatic set_length(input int unsigned len);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= t_len'(len);
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Output side: random stall per result, bursts with no stall, and the
    // long hold-off when the sender flags it.
    initial begin : result_sink
        int stall;
        int burst;
        burst = 0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (long_hold_due) begin
                long_hold_due = 1'b0;
                stall = LONG_HOLD;
            end else if (burst > 0) begin
                burst--;
                stall = 0;
            end else begin
                if ($urandom_range(0, 19) == 0) burst = $urandom_range(10, 40);
                stall = $urandom_range(0, 18);
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
        finish_run(1'b0);
    end

    initial begin : stimulus
        int unsigned lengths [8];
        int unsigned need;
        int unsigned r;
        t_in_item    it;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // length is 0 after reset: start must be refused
        send_cmd(CMD_START, 1'b1);
        send_cmd(CMD_TICK, 1'b0);          // tick while stopped
        send_cmd(CMD_STOP, 1'b0);          // stop while already stopped
        send_load(0, 1'b1, '0);            // zero duration acts as one tick
        send_load(1, 1'b0, t_dur'(2));
        send_load(2, 1'b1, t_dur'(1));
        send_load(63, 1'b1, '1);           // top slot, widest duration
        send_load(3, 1'b0, t_dur'(3));
        set_length(3);
        send_cmd(CMD_START, 1'b0);         // one-shot
        repeat (4) send_cmd(CMD_TICK, 1'b0); // walk entries, then halt past the end
        send_cmd(CMD_TICK, 1'b0);          // stopped again
        send_cmd(CMD_START, 1'b1);         // looping: wraps to entry 0
        repeat (8) send_cmd(CMD_TICK, 1'b0);
        send_cmd(CMD_STOP, 1'b0);
        send_cmd(CMD_START, 1'b1);         // left running into the next phase

        // --- random phases ---
        // first phase shrinks the length while the loop is still playing;
        // above-depth lengths act as the full table
        lengths[0] = 1;
        lengths[1] = SEQ_DEPTH;
        lengths[2] = 0;
        lengths[3] = 127;
        lengths[4] = SEQ_DEPTH + 1;
        for (int p = 5; p < 8; p++) lengths[p] = $urandom_range(0, 127);

        for (int p = 0; p < 8; p++) begin
            need = (lengths[p] > SEQ_DEPTH) ? SEQ_DEPTH : lengths[p];
            for (int s = 0; s < need; s++)
                if (!loaded[s]) send_load(s, 1'($urandom_range(0, 1)), shaped_duration());
            set_length(lengths[p]);
            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 84) begin
                    offer(shaped_item(CMD_TICK));
                end else if (r < 90) begin
                    offer(shaped_item(CMD_START));
                end else if (r < 93) begin
                    offer(shaped_item(CMD_STOP));
                end else begin
                    it = shaped_item(CMD_LOAD);
                    send_load(it.entry_index, it.entry_level, shaped_duration());
                end
            end
        end

        drain();
        finish_run(fail_count == 0 && pending == 0);
    end

endmodule

// ===== files.f =====
rtl/core/psg_pkg.sv
rtl/core/psg_table.sv
rtl/core/psg_engine.sv
rtl/core/pulse_sequence_generator_unit.sv
verif/psg_playback_checker.sv
verif/pulse_sequence_generator_unit_test.sv
